/* src/stepper_linear_ramp_profile_macros.svh */
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_LINEAR_RAMP_PROFILE_MACROS_SVH
`define STEPPER_LINEAR_RAMP_PROFILE_MACROS_SVH

// check cons on the same edge as ante
`define SLRP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slrp: same-cycle check failed");

// check cons on the edge after ante
`define SLRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slrp: next-cycle check failed");

`endif

/* src/slrp_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - package
// Types, command/status bundles and fixed constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package slrp_pkg;

    localparam int HALF_W    = 16;
    localparam int MAG_W     = 15;
    localparam int PROD_W    = 31;
    localparam int HOLD_W    = 5;
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 3;

    localparam logic [HALF_W-1:0] START_RESET  = 16'd3000;
    localparam logic [HALF_W-1:0] TARGET_RESET = 16'd400;
    localparam logic [HALF_W-1:0] RAMP_RESET   = 16'd1500;
    localparam logic [HALF_W-1:0] HALF_MIN     = 16'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 2'd2;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ACCEL   = 3'd1,
        PH_CRUISE  = 3'd2,
        PH_HOLD1   = 3'd3,
        PH_RELEASE = 3'd4,
        PH_HOLD2   = 3'd5,
        PH_DECEL   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_DONE
    } seq_t;

    typedef enum logic [1:0] {
        HALF_START,
        HALF_TARGET,
        HALF_ACCEL,
        HALF_DECEL
    } half_sel_t;

    typedef struct packed {
        logic      prep;
        logic      mul;
        logic      div_step;
        logic      half_we;
        half_sel_t half_sel;
        logic      elapsed_clr;
        logic      elapsed_inc;
        logic      out_load;
        logic      out_written;
        phase_t    out_phase;
    } cmd_t;

    typedef struct packed {
        logic elapsed_done;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

/* src/slrp_datapath.sv */
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - datapath
// Config registers, clamps, ramp counter, multiplier, bit-serial divider,
// half period register and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module slrp_datapath #(
    parameter int HALF_PERIOD_MAX = 32768
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [slrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [slrp_pkg::HALF_W-1:0]       cfg_data,
    input  slrp_pkg::cmd_t                   cmd,
    output slrp_pkg::status_t                status,
    input  wire                              out_stall,
    output logic                             out_valid,
    output logic [slrp_pkg::HALF_W-1:0]      half_period,
    output logic [slrp_pkg::HALF_W-1:0]      reload_value,
    output logic                             period_written,
    output logic                             pulses_enabled,
    output logic [slrp_pkg::PHASE_W-1:0]     phase_now
);
    import slrp_pkg::*;

    localparam logic [HALF_W-1:0] HMAX = HALF_W'(HALF_PERIOD_MAX);

    logic [HALF_W-1:0]    start_reg;
    logic [HALF_W-1:0]    target_reg;
    logic [HALF_W-1:0]    ramp_reg;
    logic [HALF_W-1:0]    elapsed_reg;
    logic [HALF_W-1:0]    current_half_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [HALF_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 out_valid_reg;
    logic [HALF_W-1:0]    out_half_reg;
    logic [HALF_W-1:0]    out_reload_reg;
    logic                 out_written_reg;
    phase_t               out_phase_reg;

    logic [HALF_W-1:0]    s_clamp;
    logic [HALF_W-1:0]    t_clamp;
    logic [HALF_W-1:0]    r_eff;
    logic [HALF_W:0]      rem_shift;
    logic [HALF_W:0]      rem_diff;
    logic                 rem_ge;
    logic [HALF_W-1:0]    q_ext;
    logic [HALF_W-1:0]    accel_half;
    logic [HALF_W-1:0]    decel_half;
    logic [HALF_W-1:0]    half_next;

    always_comb
    begin
        if (start_reg < HALF_MIN)
            s_clamp = HALF_MIN;
        else if (start_reg > HMAX)
            s_clamp = HMAX;
        else
            s_clamp = start_reg;

        if (target_reg < HALF_MIN)
            t_clamp = HALF_MIN;
        else if (target_reg > HMAX)
            t_clamp = HMAX;
        else
            t_clamp = target_reg;

        r_eff = (ramp_reg == '0) ? HALF_W'(1) : ramp_reg;
    end

    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_eff};
    assign rem_ge    = (rem_shift >= {1'b0, r_eff});

    assign q_ext      = HALF_W'(quo_reg[MAG_W-1:0]);
    assign accel_half = neg_reg ? (s_clamp + q_ext) : (s_clamp - q_ext);
    assign decel_half = neg_reg ? (t_clamp - q_ext) : (t_clamp + q_ext);

    always_comb
    begin
        half_next = current_half_reg;
        if (cmd.half_we)
        begin
            case (cmd.half_sel)
                HALF_START:  half_next = s_clamp;
                HALF_TARGET: half_next = t_clamp;
                HALF_ACCEL:  half_next = accel_half;
                HALF_DECEL:  half_next = decel_half;
                default:     half_next = current_half_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RESET;
            target_reg <= TARGET_RESET;
            ramp_reg   <= RAMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START:  start_reg  <= cfg_data;
                CFG_TARGET: target_reg <= cfg_data;
                CFG_RAMP:   ramp_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg      <= '0;
            current_half_reg <= START_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.elapsed_clr)
                elapsed_reg <= '0;
            else if (cmd.elapsed_inc)
                elapsed_reg <= elapsed_reg + HALF_W'(1);

            current_half_reg <= half_next;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            mag_reg <= (s_clamp >= t_clamp) ? MAG_W'(s_clamp - t_clamp)
                                            : MAG_W'(t_clamp - s_clamp);
            neg_reg <= (s_clamp < t_clamp);
        end

        if (cmd.mul)
        begin
            quo_reg <= PROD_W'(mag_reg) * PROD_W'(elapsed_reg);
            rem_reg <= '0;
            cnt_reg <= DIV_CNT_W'(PROD_W - 1);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[HALF_W-1:0] : rem_shift[HALF_W-1:0];
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end

        if (cmd.out_load)
        begin
            out_half_reg    <= half_next;
            out_reload_reg  <= {half_next[HALF_W-2:0], 1'b0} - HALF_W'(1);
            out_written_reg <= cmd.out_written;
            out_phase_reg   <= cmd.out_phase;
        end
    end

    assign status.elapsed_done = (elapsed_reg >= r_eff);
    assign status.div_last     = (cnt_reg == '0);
    assign status.out_busy     = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign half_period    = out_half_reg;
    assign reload_value   = out_reload_reg;
    assign period_written = out_written_reg;
    assign pulses_enabled = (out_phase_reg != PH_IDLE);
    assign phase_now      = out_phase_reg;

endmodule

`default_nettype wire

/* src/slrp_controller.sv */
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - controller
// Motion phase machine with debounce counter, and the sequencer that runs
// the multiply and serial divide for ramp ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module slrp_controller #(
    parameter int DEBOUNCE_TICKS = 20
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire                start_request,
    input  wire                stop_pressed,
    input  slrp_pkg::status_t  status,
    output slrp_pkg::cmd_t     cmd
);
    import slrp_pkg::*;

    localparam logic [HOLD_W-1:0] HOLD_LIMIT = HOLD_W'(DEBOUNCE_TICKS);

    seq_t              seq_reg;
    seq_t              seq_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic [HOLD_W-1:0] hold_inc;
    logic              accept;

    assign in_stall = (seq_reg != SEQ_IDLE) || status.out_busy;
    assign accept   = in_valid && !in_stall;
    assign hold_inc = hold_reg + HOLD_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_IDLE;
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
        end
    end

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        cmd        = '0;
        cmd.half_sel  = HALF_START;
        cmd.out_phase = phase_reg;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    cmd.out_load = 1'b1;
                    case (phase_reg)
                        PH_ACCEL:
                        begin
                            if (stop_pressed)
                            begin
                                phase_next = PH_HOLD1;
                                hold_next  = '0;
                            end
                            else if (status.elapsed_done)
                            begin
                                cmd.half_we  = 1'b1;
                                cmd.half_sel = HALF_TARGET;
                                phase_next   = PH_CRUISE;
                            end
                            else
                            begin
                                cmd.out_load = 1'b0;
                                cmd.prep     = 1'b1;
                                seq_next     = SEQ_MUL;
                            end
                        end
                        PH_CRUISE:
                        begin
                            if (stop_pressed)
                            begin
                                phase_next = PH_HOLD1;
                                hold_next  = '0;
                            end
                        end
                        PH_HOLD1:
                        begin
                            if (hold_inc >= HOLD_LIMIT)
                            begin
                                phase_next = PH_RELEASE;
                                hold_next  = '0;
                            end
                            else
                                hold_next = hold_inc;
                        end
                        PH_RELEASE:
                        begin
                            if (!stop_pressed)
                            begin
                                phase_next = PH_HOLD2;
                                hold_next  = '0;
                            end
                        end
                        PH_HOLD2:
                        begin
                            if (hold_inc >= HOLD_LIMIT)
                            begin
                                phase_next      = PH_DECEL;
                                hold_next       = '0;
                                cmd.elapsed_clr = 1'b1;
                            end
                            else
                                hold_next = hold_inc;
                        end
                        PH_DECEL:
                        begin
                            if (status.elapsed_done)
                            begin
                                cmd.half_we  = 1'b1;
                                cmd.half_sel = HALF_START;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                cmd.out_load = 1'b0;
                                cmd.prep     = 1'b1;
                                seq_next     = SEQ_MUL;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            if (start_request)
                            begin
                                cmd.half_we     = 1'b1;
                                cmd.half_sel    = HALF_START;
                                cmd.elapsed_clr = 1'b1;
                                phase_next      = PH_ACCEL;
                                hold_next       = '0;
                            end
                        end
                    endcase
                    cmd.out_written = cmd.half_we;
                    cmd.out_phase   = phase_next;
                end
            end
            SEQ_MUL:
            begin
                cmd.mul  = 1'b1;
                seq_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    seq_next = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.half_we     = 1'b1;
                    cmd.half_sel    = (phase_reg == PH_DECEL) ? HALF_DECEL : HALF_ACCEL;
                    cmd.elapsed_inc = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.out_written = 1'b1;
                    seq_next        = SEQ_IDLE;
                end
            end
            default:
                seq_next = SEQ_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* src/stepper_linear_ramp_profile.sv */
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - top level
// Trapezoidal step rate generator: one input word per 1 ms tick, one result
// word per tick. A tick that needs no ramp point (idle, cruise, holds,
// release wait, ramp end, STOP during accelerate) loads its result word when
// it is accepted. A ramp point during accelerate or decelerate runs in steps:
// one to form |start - target|, one 15x16 multiply by the elapsed count, the
// one-bit-a-cycle restoring divider by the ramp length, and one to apply
// the new half period once the output is free. Config writes are always
// ready and take effect at once; write them only between ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_linear_ramp_profile #(
    parameter int DEBOUNCE_TICKS  = 20,
    parameter int HALF_PERIOD_MAX = 32768
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [slrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [slrp_pkg::HALF_W-1:0]       cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              start_request,
    input  wire                              stop_pressed,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [slrp_pkg::HALF_W-1:0]      half_period,
    output logic [slrp_pkg::HALF_W-1:0]      reload_value,
    output logic                             period_written,
    output logic                             pulses_enabled,
    output logic [slrp_pkg::PHASE_W-1:0]     phase_now
);
    import slrp_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    slrp_controller #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_request (start_request),
        .stop_pressed  (stop_pressed),
        .status        (status),
        .cmd           (cmd)
    );

    slrp_datapath #(
        .HALF_PERIOD_MAX (HALF_PERIOD_MAX)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .half_period    (half_period),
        .reload_value   (reload_value),
        .period_written (period_written),
        .pulses_enabled (pulses_enabled),
        .phase_now      (phase_now)
    );

endmodule

`default_nettype wire

/* src/slrp_checker.sv */
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - port checker
// Watches the top-level ports for output word consistency and flow control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_linear_ramp_profile_macros.svh"

module slrp_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_stall,
    input wire                              out_valid,
    input wire                              out_stall,
    input wire [slrp_pkg::HALF_W-1:0]       half_period,
    input wire [slrp_pkg::HALF_W-1:0]       reload_value,
    input wire                              pulses_enabled,
    input wire [slrp_pkg::PHASE_W-1:0]      phase_now
);
    import slrp_pkg::*;

    `SLRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({half_period, phase_now}))
    `SLRP_ASSERT_SAME(a_reload, out_valid, reload_value == ({half_period[HALF_W-2:0], 1'b0} - 16'd1))
    `SLRP_ASSERT_SAME(a_pulses, out_valid, pulses_enabled == (phase_now != PHASE_W'(PH_IDLE)))
    `SLRP_ASSERT_SAME(a_no_overrun, out_valid && out_stall, in_stall)
    `SLRP_ASSERT_SAME(a_half_min, out_valid, half_period >= HALF_MIN)

endmodule

bind stepper_linear_ramp_profile slrp_checker u_slrp_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper linear ramp profile - testbench
// Feeds millisecond tick words to the ramp generator and checks every result
// word against a cycle-free model of the trapezoidal profile. Register
// settings change between phases, and both channels idle in random bursts.
// ----------------------------------------------------------------------------

module tb;
    import slrp_pkg::*;

    localparam int DEBOUNCE       = 20;
    localparam int HALF_MAX       = 32768;
    localparam int TICK_COUNT     = 700;
    localparam int QUIET_AFTER    = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE         = 40;

    typedef struct {
        bit start;
        bit stop;
    } tick_word_t;

    typedef struct {
        bit [15:0] half;
        bit [15:0] reload;
        bit        written;
        bit        pulses;
        phase_t    phase;
    } profile_word_t;

    typedef struct {
        phase_t    phase;
        bit [15:0] elapsed;
        bit [4:0]  hold;
        bit [15:0] half;
    } ramp_state_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_START;
    logic [HALF_W-1:0]    cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic                 start_request = 1'b0;
    logic                 stop_pressed  = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [HALF_W-1:0]    half_period;
    logic [HALF_W-1:0]    reload_value;
    logic                 period_written;
    logic                 pulses_enabled;
    logic [PHASE_W-1:0]   phase_now;

    bit [15:0]     start_reg  = START_RESET;
    bit [15:0]     target_reg = TARGET_RESET;
    bit [15:0]     ramp_reg   = RAMP_RESET;
    ramp_state_t   live       = '{PH_IDLE, 16'd0, 5'd0, START_RESET};
    tick_word_t    tick_words[$];
    profile_word_t expected_words[$];

    int     queued       = 0;
    int     accepted     = 0;
    int     checked      = 0;
    int     failures     = 0;
    int     reg_writes   = 0;
    int     settings     = 0;
    int     quiet_cycles = 0;
    int     in_gap       = 0;
    int     out_hold     = 0;
    int     in_idle_rate = 60;
    int     out_idle_rate = 60;
    bit     in_fired     = 1'b0;
    bit     quiet        = 1'b0;
    bit [7:0] phases_seen = '0;

    stepper_linear_ramp_profile dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_request  (start_request),
        .stop_pressed   (stop_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .half_period    (half_period),
        .reload_value   (reload_value),
        .period_written (period_written),
        .pulses_enabled (pulses_enabled),
        .phase_now      (phase_now)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit [15:0] clamp_half(input longint v);
        bit [31:0] u;
        u = v[31:0];
        if (u < 2)
            return HALF_MIN;
        if (u > HALF_MAX)
            return 16'(HALF_MAX);
        return u[15:0];
    endfunction

    function automatic profile_word_t advance_profile(inout ramp_state_t st,
                                                      input bit start, input bit stop);
        longint        s;
        longint        t;
        longint        r;
        longint        e;
        bit            wrote;
        profile_word_t w;
        s = clamp_half(start_reg);
        t = clamp_half(target_reg);
        r = (ramp_reg == 0) ? 1 : ramp_reg;
        e = st.elapsed;
        wrote = 1'b0;
        case (st.phase)
            PH_ACCEL:
            begin
                if (stop)
                begin
                    st.phase = PH_HOLD1;
                    st.hold = '0;
                end
                else if (e >= r)
                begin
                    st.half = 16'(t);
                    wrote = 1'b1;
                    st.phase = PH_CRUISE;
                end
                else
                begin
                    st.half = clamp_half(s - ((s - t) * e) / r);
                    wrote = 1'b1;
                    st.elapsed = st.elapsed + 16'd1;
                end
            end
            PH_CRUISE:
            begin
                if (stop)
                begin
                    st.phase = PH_HOLD1;
                    st.hold = '0;
                end
            end
            PH_HOLD1:
            begin
                st.hold = st.hold + 5'd1;
                if (st.hold >= DEBOUNCE)
                begin
                    st.phase = PH_RELEASE;
                    st.hold = '0;
                end
            end
            PH_RELEASE:
            begin
                if (!stop)
                begin
                    st.phase = PH_HOLD2;
                    st.hold = '0;
                end
            end
            PH_HOLD2:
            begin
                st.hold = st.hold + 5'd1;
                if (st.hold >= DEBOUNCE)
                begin
                    st.phase = PH_DECEL;
                    st.hold = '0;
                    st.elapsed = '0;
                end
            end
            PH_DECEL:
            begin
                if (e >= r)
                begin
                    st.half = 16'(s);
                    wrote = 1'b1;
                    st.phase = PH_IDLE;
                end
                else
                begin
                    st.half = clamp_half(t + ((s - t) * e) / r);
                    wrote = 1'b1;
                    st.elapsed = st.elapsed + 16'd1;
                end
            end
            default:
            begin
                st.phase = PH_IDLE;
                if (start)
                begin
                    st.half = 16'(s);
                    wrote = 1'b1;
                    st.phase = PH_ACCEL;
                    st.elapsed = '0;
                    st.hold = '0;
                end
            end
        endcase
        w.half    = st.half;
        w.reload  = {st.half[14:0], 1'b0} - 16'd1;
        w.written = wrote;
        w.pulses  = (st.phase != PH_IDLE);
        w.phase   = st.phase;
        return w;
    endfunction

    function automatic bit [15:0] pick_half();
        bit [15:0] corners [8] = '{16'd0, 16'd1, 16'd2, 16'd3,
                                   16'd32767, 16'd32768, 16'd32769, 16'd65535};
        case ($urandom_range(0, 3))
            0: return corners[$urandom_range(0, 7)];
            1: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(2, 600));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic push_word(input bit start, input bit stop);
        tick_words.push_back('{start, stop});
        queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_START:  start_reg  = val;
            CFG_TARGET: target_reg = val;
            CFG_RAMP:   ramp_reg   = val;
            default:    ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (accepted != queued || expected_words.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic plan_phase(input int n);
        ramp_state_t plan;
        bit          start;
        bit          stop;
        bit          big;
        plan = live;
        big = (ramp_reg > 60);
        for (int i = 0; i < n; i++)
        begin
            start = 1'($urandom_range(0, 1));
            stop  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 11) != 0)
            begin
                case (plan.phase)
                    PH_IDLE:    start = ($urandom_range(0, 3) != 0);
                    PH_ACCEL:   stop = big ? ($urandom_range(0, 15) == 0)
                                           : ($urandom_range(0, 24) == 0);
                    PH_CRUISE:  stop = ($urandom_range(0, 2) == 0);
                    PH_RELEASE: stop = ($urandom_range(0, 3) != 0);
                    default:    ;
                endcase
            end
            push_word(start, stop);
            void'(advance_profile(plan, start, stop));
        end
    endtask

    always @(negedge clk)
    begin
        tick_word_t w;
        bit         drive;
        drive = in_valid;
        if (!in_valid || in_fired)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                drive = 1'b0;
            end
            else if (tick_words.size() > 0)
            begin
                w = tick_words.pop_front();
                start_request <= w.start;
                stop_pressed  <= w.stop;
                drive = 1'b1;
                if (!quiet && $urandom_range(0, 999) < in_idle_rate)
                    in_gap = $urandom_range(1, 17);
            end
            else
                drive = 1'b0;
        end
        in_valid <= drive;
        if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 999) < out_idle_rate)
                out_hold = $urandom_range(1, 17);
        end
    end

    always @(posedge clk)
    begin
        profile_word_t want;
        bit            out_fired;
        if (rst_n)
        begin
            in_fired = in_valid && !in_stall;
            out_fired = out_valid && !out_stall;
            if (in_fired)
            begin
                expected_words.push_back(advance_profile(live, start_request, stop_pressed));
                accepted++;
            end
            if (out_fired)
            begin
                checked++;
                if (expected_words.size() == 0)
                begin
                    $error("result word with no tick pending");
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    phases_seen[want.phase] = 1'b1;
                    check_field("half_period", half_period, want.half);
                    check_field("reload_value", reload_value, want.reload);
                    check_field("period_written", 16'(period_written), 16'(want.written));
                    check_field("pulses_enabled", 16'(pulses_enabled), 16'(want.pulses));
                    check_field("phase_now", 16'(phase_now), 16'(want.phase));
                end
            end
            if (in_fired || out_fired || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int rates [3];
        bit shrink;
        bit first;
        rates = '{0, 60, 250};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settings++;
        push_word(1'b0, 1'b1);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b1);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b0);
        drain();

        settings++;
        write_reg(CFG_START, 16'hFFFF);
        write_reg(CFG_TARGET, 16'd0);
        write_reg(CFG_RAMP, 16'd0);
        @(posedge clk);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b0);
        push_word(1'b0, 1'b1);
        for (int i = 0; i < DEBOUNCE; i++)
            push_word(i[0], !i[0]);
        push_word(1'b0, 1'b1);
        push_word(1'b1, 1'b1);
        push_word(1'b0, 1'b0);
        for (int i = 0; i < DEBOUNCE; i++)
            push_word(!i[0], i[0]);
        push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b1);
        push_word(1'b0, 1'b0);
        drain();

        settings++;
        write_reg(CFG_START, 16'd1);
        write_reg(CFG_TARGET, 16'd32769);
        write_reg(CFG_RAMP, 16'd3);
        @(posedge clk);
        push_word(1'b1, 1'b0);
        push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b0);
        push_word(1'b1, 1'b1);
        drain();

        shrink = 1'b0;
        first = 1'b1;
        while (queued < TICK_COUNT)
        begin
            quiet = (queued >= QUIET_AFTER);
            in_idle_rate = rates[$urandom_range(0, 2)];
            out_idle_rate = rates[$urandom_range(0, 2)];
            if (first || $urandom_range(0, 2) != 0)
                write_reg(CFG_START, pick_half());
            if (first || $urandom_range(0, 2) != 0)
                write_reg(CFG_TARGET, pick_half());
            if (shrink)
                write_reg(CFG_RAMP, 16'($urandom_range(0, 12)));
            else if (first || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_RAMP, ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1);
                    1: write_reg(CFG_RAMP, 16'($urandom_range(25, 65535)));
                    default: write_reg(CFG_RAMP, 16'($urandom_range(0, 24)));
                endcase
            end
            shrink = (ramp_reg > 60);
            first = 1'b0;
            settings++;
            @(posedge clk);
            plan_phase($urandom_range(30, 120));
            drain();
        end

        if (expected_words.size() != 0)
        begin
            $error("%0d result words never arrived", expected_words.size());
            failures++;
        end
        $display("Ran %0d tick words, checked %0d result words over %0d settings (%0d writes).",
                 accepted, checked, settings, reg_writes);
        $display("Profile phases reached: %0d of 7.", $countones(phases_seen));
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
